// ----- hw/rtl/u8svd_pkg.sv -----
`default_nettype none

package u8svd_pkg;

    // Count ceiling: the lesser of this and 65535.
    localparam logic [31:0] MAX_STRING_BYTES = 32'd65535;
    localparam logic [15:0] COUNT_CAP =
        (MAX_STRING_BYTES < 32'd65535) ? 16'(MAX_STRING_BYTES) : 16'hFFFF;

    localparam logic [20:0] MIN_CP_2 = 21'h00080;
    localparam logic [20:0] MIN_CP_3 = 21'h00800;
    localparam logic [20:0] MIN_CP_4 = 21'h10000;
    localparam logic [20:0] SURR_LO  = 21'h0D800;
    localparam logic [20:0] SURR_HI  = 21'h0DFFF;
    localparam logic [20:0] MAX_CP   = 21'h10FFFF;

    typedef enum logic [1:0] {
        ST_UNIT      = 2'd0,
        ST_NUL       = 2'd1,
        ST_INVALID   = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] unit_count;
        logic [15:0] byte_count;
        status_t     status;
        logic [2:0]  unit_bytes;
        logic [20:0] code_point;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/utf8_stream_validate_decode_core.sv -----
`default_nettype none

// UTF-8 validator and decoder, one byte per transaction on the s_ side. A
// byte with s_tuser set starts a new string (clears counts and the stop flag);
// s_tlast marks the final byte of the buffer. Each completed code unit yields
// one result on the m_ side with the code point, unit length, status and
// saturating running byte and unit counts; m_tlast is set when the string
// ends (NUL, invalid/truncated unit, or buffer exhausted). Lead bytes of a
// multi-byte unit, unless it is the final byte of the buffer, and bytes after
// a stop give no result. Throughput is one byte per clock: decode is a single
// combinational step on the running state, and the result sits in a one-deep
// output register, so s_tready drops only while that register is full and
// m_tready is low; a result is shown in the cycle after its byte is accepted.
module utf8_stream_validate_decode_core
    import u8svd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] string_start
    input  wire logic        s_tlast,   // end of buffer
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [20:0] code_point, [23:21] unit_bytes,
                                        // [25:24] status, [41:26] byte_count,
                                        // [57:42] unit_count, [63:58] zero
    output logic             m_tlast    // last
);

    logic [1:0]  tails_reg, tails_next;
    logic [20:0] accum_reg, accum_next;
    logic [2:0]  ulen_reg, ulen_next;
    logic [15:0] vbytes_reg, vbytes_next;
    logic [15:0] vunits_reg, vunits_next;
    logic        stopped_reg, stopped_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    logic        accept;
    logic        emit;
    logic [1:0]  cur_tails;
    logic [15:0] cur_vbytes;
    logic [15:0] cur_vunits;
    logic        cur_stopped;
    logic [20:0] cont_accum;
    logic [2:0]  done_len;
    logic [20:0] done_cp;
    logic        bad_value;
    logic [16:0] bytes_sum;
    logic [16:0] units_sum;
    logic [15:0] bytes_sat;
    logic [15:0] units_sat;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // A new string clears the running state before its first byte is handled.
    assign cur_tails   = s_tuser ? 2'd0  : tails_reg;
    assign cur_vbytes  = s_tuser ? 16'd0 : vbytes_reg;
    assign cur_vunits  = s_tuser ? 16'd0 : vunits_reg;
    assign cur_stopped = s_tuser ? 1'b0  : stopped_reg;

    assign cont_accum = {accum_reg[14:0], s_tdata[5:0]};

    // Completed unit: ASCII byte when no tails pending, else the accumulated value.
    assign done_len = (cur_tails == 2'd0) ? 3'd1 : ulen_reg;
    assign done_cp  = (cur_tails == 2'd0) ? {13'd0, s_tdata} : cont_accum;

    assign bad_value = (cont_accum < MIN_CP_2 && ulen_reg == 3'd2)
                    || (cont_accum < MIN_CP_3 && ulen_reg == 3'd3)
                    || (cont_accum < MIN_CP_4 && ulen_reg == 3'd4)
                    || (cont_accum >= SURR_LO && cont_accum <= SURR_HI)
                    || (cont_accum > MAX_CP);

    assign bytes_sum = {1'b0, cur_vbytes} + 17'(done_len);
    assign units_sum = {1'b0, cur_vunits} + 17'd1;
    assign bytes_sat = (bytes_sum > {1'b0, COUNT_CAP}) ? COUNT_CAP : bytes_sum[15:0];
    assign units_sat = (units_sum > {1'b0, COUNT_CAP}) ? COUNT_CAP : units_sum[15:0];

    always_comb
    begin
        tails_next   = cur_tails;
        accum_next   = accum_reg;
        ulen_next    = ulen_reg;
        vbytes_next  = cur_vbytes;
        vunits_next  = cur_vunits;
        stopped_next = cur_stopped;
        emit         = 1'b0;
        out_next     = out_reg;

        if (!cur_stopped) begin
            // error unless overwritten below
            out_next.code_point = '0;
            out_next.unit_bytes = '0;
            out_next.status     = ST_INVALID;
            out_next.byte_count = cur_vbytes;
            out_next.unit_count = cur_vunits;

            if (cur_tails == 2'd0) begin
                if (!s_tdata[7]) begin
                    emit = 1'b1;
                end else if (s_tdata[7:5] == 3'b110) begin
                    accum_next = {16'd0, s_tdata[4:0]};
                    ulen_next  = 3'd2;
                    tails_next = 2'd1;
                end else if (s_tdata[7:4] == 4'b1110) begin
                    accum_next = {17'd0, s_tdata[3:0]};
                    ulen_next  = 3'd3;
                    tails_next = 2'd2;
                end else if (s_tdata[7:3] == 5'b11110) begin
                    accum_next = {18'd0, s_tdata[2:0]};
                    ulen_next  = 3'd4;
                    tails_next = 2'd3;
                end else begin
                    emit = 1'b1;
                end
                // lead byte on the final byte of the buffer: truncated
                if (s_tdata[7] && s_tlast)
                    emit = 1'b1;
            end else begin
                accum_next = cont_accum;
                tails_next = cur_tails - 2'd1;
                if (s_tdata[7:6] != 2'b10 || cur_tails != 2'd1 && s_tlast
                    || cur_tails == 2'd1 && bad_value)
                    emit = 1'b1;
                else if (cur_tails == 2'd1)
                    emit = 1'b1;
            end

            // good completion: ASCII byte, or last tail that passes all checks
            if ((cur_tails == 2'd0 && !s_tdata[7])
                || (cur_tails == 2'd1 && s_tdata[7:6] == 2'b10 && !bad_value)) begin
                vbytes_next         = bytes_sat;
                vunits_next         = units_sat;
                out_next.code_point = done_cp;
                out_next.unit_bytes = done_len;
                out_next.byte_count = bytes_sat;
                out_next.unit_count = units_sat;
                if (done_len == 3'd1 && done_cp == 21'd0)
                    out_next.status = ST_NUL;
                else if (s_tlast)
                    out_next.status = ST_EXHAUSTED;
                else
                    out_next.status = ST_UNIT;
            end

            if (emit && out_next.status != ST_UNIT) begin
                stopped_next = 1'b1;
                tails_next   = 2'd0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (accept && emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tails_reg     <= '0;
            accum_reg     <= '0;
            ulen_reg      <= '0;
            vbytes_reg    <= '0;
            vunits_reg    <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                tails_reg   <= tails_next;
                accum_reg   <= accum_next;
                ulen_reg    <= ulen_next;
                vbytes_reg  <= vbytes_next;
                vunits_reg  <= vunits_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg};
    assign m_tlast  = (out_reg.status != ST_UNIT);

    // No continuation bytes can be pending once the string has stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> tails_reg == 2'd0)
        else $error("tails pending after stop");

    // Invalid-unit results carry no code point and no length.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.status == ST_INVALID
            |-> out_reg.code_point == 21'd0 && out_reg.unit_bytes == 3'd0)
        else $error("invalid result with payload");

    // Every unit has at least one byte, so the byte count never trails the unit count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_reg.byte_count >= out_reg.unit_count)
        else $error("byte count below unit count");

    // An ending result always stops the string.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit && out_next.status != ST_UNIT |=> stopped_reg)
        else $error("string not stopped after final result");

endmodule

`default_nettype wire

// ----- test/tb_utf8_stream_validate_decode_core.sv -----
`timescale 1ns / 1ps

module tb_utf8_stream_validate_decode_core;
    import u8svd_pkg::*;

    typedef struct {
        result_t fields;
        logic    last;
    } decoded_t;

    typedef enum {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_BURSTY
    } ready_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic        s_tuser = 1'b0;    // [0] string_start
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // [20:0] code_point, [23:21] unit_bytes, [25:24] status,
                                    // [41:26] byte_count, [57:42] unit_count
    logic        m_tlast;

    utf8_stream_validate_decode_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Decoder state mirror
    logic [1:0]  tails_left = '0;
    logic [20:0] code_accum = '0;
    logic [2:0]  unit_length = '0;
    logic [15:0] valid_bytes = '0;
    logic [15:0] valid_units = '0;
    logic        stopped = 1'b0;

    decoded_t    pending_units[$];
    logic [7:0]  string_bytes[$];
    int          bytes_sent = 0;
    int          burst_left = 0;
    int          mismatch_count = 0;
    int          orphan_count = 0;

    function automatic logic [15:0] sat_count(input logic [15:0] cnt, input logic [2:0] inc);
        logic [16:0] sum;
        sum = {1'b0, cnt} + 17'(inc);
        return (sum > {1'b0, COUNT_CAP}) ? COUNT_CAP : sum[15:0];
    endfunction

    task automatic post_result(input logic [20:0] cp, input logic [2:0] len, input status_t st);
        decoded_t r;
        r.fields.code_point = cp;
        r.fields.unit_bytes = len;
        r.fields.status     = st;
        r.fields.byte_count = valid_bytes;
        r.fields.unit_count = valid_units;
        r.last              = (st != ST_UNIT);
        pending_units.push_back(r);
        if (st != ST_UNIT)
        begin
            stopped    = 1'b1;
            tails_left = '0;
        end
    endtask

    task automatic finish_unit(input logic [20:0] cp, input logic [2:0] len, input logic fin);
        valid_bytes = sat_count(valid_bytes, len);
        valid_units = sat_count(valid_units, 3'd1);
        if (len == 3'd1 && cp == '0)
            post_result('0, 3'd1, ST_NUL);
        else
            post_result(cp, len, fin ? ST_EXHAUSTED : ST_UNIT);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start, input logic fin);
        logic [2:0]  len;
        logic [20:0] cp;
        if (start)
        begin
            tails_left  = '0;
            code_accum  = '0;
            unit_length = '0;
            valid_bytes = '0;
            valid_units = '0;
            stopped     = 1'b0;
        end
        if (stopped)
            return;
        if (tails_left == '0)
        begin
            if (b[7] == 1'b0)
            begin
                finish_unit({13'd0, b}, 3'd1, fin);
                return;
            end
            else if (b[7:5] == 3'b110)
                len = 3'd2;
            else if (b[7:4] == 4'b1110)
                len = 3'd3;
            else if (b[7:3] == 5'b11110)
                len = 3'd4;
            else
            begin
                post_result('0, '0, ST_INVALID);
                return;
            end
            if (fin)
            begin
                post_result('0, '0, ST_INVALID);
                return;
            end
            code_accum  = 21'(b & (8'hFF >> (len + 3'd1)));
            unit_length = len;
            tails_left  = 2'(len - 3'd1);
            return;
        end
        if (b[7:6] != 2'b10)
        begin
            post_result('0, '0, ST_INVALID);
            return;
        end
        code_accum = {code_accum[14:0], b[5:0]};
        tails_left = tails_left - 2'd1;
        if (tails_left != '0)
        begin
            if (fin)
                post_result('0, '0, ST_INVALID);
            return;
        end
        cp = code_accum;
        if ((cp < MIN_CP_2 && unit_length == 3'd2) || (cp < MIN_CP_3 && unit_length == 3'd3) ||
            (cp < MIN_CP_4 && unit_length == 3'd4) || (cp >= SURR_LO && cp <= SURR_HI) ||
            cp > MAX_CP)
            post_result('0, '0, ST_INVALID);
        else
            finish_unit(cp, unit_length, fin);
    endtask

    // One byte on the slave side; bursts of random length with random gaps.
    task automatic send_byte(input logic [7:0] b, input logic start, input logic fin);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = start;
        s_tlast  = fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        decode_byte(b, start, fin);
    endtask

    task automatic send_bytes(input logic [7:0] seq[$], input logic open_string,
                              input logic close_buffer);
        foreach (seq[i])
            send_byte(seq[i], open_string && i == 0, close_buffer && i == seq.size() - 1);
    endtask

    task automatic push_unit(input logic [20:0] cp, input int len);
        case (len)
            1: string_bytes.push_back({1'b0, cp[6:0]});
            2:
            begin
                string_bytes.push_back({3'b110, cp[10:6]});
                string_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                string_bytes.push_back({4'b1110, cp[15:12]});
                string_bytes.push_back({2'b10, cp[11:6]});
                string_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                string_bytes.push_back({5'b11110, cp[20:18]});
                string_bytes.push_back({2'b10, cp[17:12]});
                string_bytes.push_back({2'b10, cp[11:6]});
                string_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic push_random_unit();
        int          len;
        logic [20:0] cp;
        len = $urandom_range(1, 4);
        case (len)
            1: cp = 21'($urandom_range(1, 127));
            2: cp = 21'($urandom_range(21'h80, 21'h7FF));
            3:
            begin
                cp = 21'($urandom_range(21'h800, 21'hFFFF));
                if (cp >= SURR_LO && cp <= SURR_HI)
                    cp = cp ^ 21'h2000;
            end
            default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        push_unit(cp, len);
    endtask

    task automatic push_invalid_unit();
        int         len;
        int         pos;
        logic [7:0] b;
        len = $urandom_range(2, 4);
        case ($urandom_range(0, 4))
            0: string_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                           : 8'($urandom_range(8'hF8, 8'hFF)));
            1:
            begin
                // broken continuation somewhere inside a good unit
                pos = string_bytes.size() + $urandom_range(1, len - 1);
                push_unit(21'h10000 + 21'($urandom_range(0, 21'hFFFF)) >> ((4 - len) * 5), len);
                b = 8'($urandom);
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                string_bytes[pos] = b;
            end
            2: push_unit((len == 2) ? 21'($urandom_range(0, 21'h7F)) :
                         (len == 3) ? 21'($urandom_range(0, 21'h7FF)) :
                                      21'($urandom_range(0, 21'hFFFF)), len);
            3: push_unit(21'($urandom_range(SURR_LO, SURR_HI)), 3);
            default: push_unit(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
        endcase
    endtask

    task automatic test_valid_forms();
        send_bytes('{8'h41}, 1'b0, 1'b0);   // no string_start after reset
        send_bytes('{8'hC2, 8'h80}, 1'b0, 1'b0);
        send_bytes('{8'hDF, 8'hBF}, 1'b0, 1'b0);
        send_bytes('{8'hE0, 8'hA0, 8'h80}, 1'b0, 1'b0);
        send_bytes('{8'hED, 8'h9F, 8'hBF}, 1'b0, 1'b0);
        send_bytes('{8'hF0, 8'h90, 8'h80, 8'h80}, 1'b0, 1'b0);
        send_bytes('{8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b0, 1'b0);
        send_bytes('{8'h7F, 8'h00}, 1'b0, 1'b0);
        send_bytes('{8'h41, 8'hC2}, 1'b0, 1'b1);  // after NUL: dropped
    endtask

    task automatic test_invalid_units();
        send_bytes('{8'h80}, 1'b1, 1'b0);
        send_bytes('{8'hFF}, 1'b1, 1'b0);
        send_bytes('{8'hC1, 8'hBF}, 1'b1, 1'b0);
        send_bytes('{8'hE0, 8'h9F, 8'hBF}, 1'b1, 1'b0);
        send_bytes('{8'hED, 8'hA0, 8'h80}, 1'b1, 1'b0);
        send_bytes('{8'hF4, 8'h90, 8'h80, 8'h80}, 1'b1, 1'b0);
        send_bytes('{8'hC3, 8'h41}, 1'b1, 1'b0);
    endtask

    task automatic test_buffer_end();
        send_bytes('{8'hC3}, 1'b1, 1'b1);
        send_bytes('{8'hE2, 8'h82}, 1'b1, 1'b1);
        send_bytes('{8'h7A}, 1'b1, 1'b1);
        send_bytes('{8'hE2, 8'h82, 8'hAC}, 1'b1, 1'b1);
        send_bytes('{8'h41, 8'h00}, 1'b1, 1'b1);
    endtask

    task automatic test_random_strings(input int target);
        int   goal;
        int   len;
        logic with_end;
        goal = bytes_sent + target;
        while (bytes_sent < goal)
        begin
            string_bytes.delete();
            repeat (($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8))
                push_random_unit();
            with_end = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    if (string_bytes.size() == 0)
                        push_random_unit();
                    with_end = 1'b1;
                end
                3, 4:
                begin
                    push_unit('0, 1);
                    repeat ($urandom_range(0, 3))
                        string_bytes.push_back(8'($urandom));
                end
                5, 6, 7:
                begin
                    push_invalid_unit();
                    repeat ($urandom_range(0, 3))
                        string_bytes.push_back(8'($urandom));
                end
                8:
                begin
                    len = $urandom_range(2, 4);
                    push_unit(21'h10000 >> ((4 - len) * 5), len);
                    repeat ($urandom_range(1, len - 1))
                        void'(string_bytes.pop_back());
                    with_end = ($urandom_range(0, 3) != 0);
                end
                default:
                    repeat ($urandom_range(1, 12))
                        string_bytes.push_back(8'($urandom));
            endcase
            send_bytes(string_bytes, $urandom_range(0, 9) != 0, with_end);
        end
    endtask

    // Master-side backpressure
    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left = 0;
    int          stall_left = 0;
    int          phase = 0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 400);
        end
        mode_left--;
        phase++;
        case (ready_mode)
            READY_ALWAYS:   m_tready <= 1'b1;
            READY_COIN:     m_tready <= 1'($urandom_range(0, 1));
            READY_PERIODIC: m_tready <= (phase % 4 != 3);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 12);
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    task automatic note_mismatch(input string field, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s at %0t: expected 0x%0h, actual 0x%0h", field, $time, want, got);
    endtask

    decoded_t want;
    result_t  got;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_units.size() == 0)
            begin
                orphan_count++;
                if (orphan_count <= 10)
                    $display("unexpected transaction at %0t: tdata 0x%0h", $time, m_tdata);
            end
            else
            begin
                want = pending_units.pop_front();
                got  = result_t'(m_tdata[57:0]);
                if (got.code_point != want.fields.code_point)
                    note_mismatch("code_point", want.fields.code_point, got.code_point);
                if (got.unit_bytes != want.fields.unit_bytes)
                    note_mismatch("unit_bytes", want.fields.unit_bytes, got.unit_bytes);
                if (got.status != want.fields.status)
                    note_mismatch("status", int'(want.fields.status), int'(got.status));
                if (got.byte_count != want.fields.byte_count)
                    note_mismatch("byte_count", want.fields.byte_count, got.byte_count);
                if (got.unit_count != want.fields.unit_count)
                    note_mismatch("unit_count", want.fields.unit_count, got.unit_count);
                if (m_tdata[63:58] != '0)
                    note_mismatch("tdata pad", 0, m_tdata[63:58]);
                if (m_tlast != want.last)
                    note_mismatch("tlast", want.last, m_tlast);
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_valid_forms();
        test_invalid_units();
        test_buffer_end();
        test_random_strings(1750);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && orphan_count == 0)
            $display("[utf8_stream_validate_decode_core] OK");
        else
            $display("[utf8_stream_validate_decode_core] ERROR");
        $finish;
    end

    initial
    begin
        #(50_000_000);
        $display("[utf8_stream_validate_decode_core] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/u8svd_pkg.sv
hw/rtl/utf8_stream_validate_decode_core.sv
test/tb_utf8_stream_validate_decode_core.sv
